// File: design/bdmm_pkg.sv
// ----------------------------------------------------------------------------
// bdmm_pkg
// Shared types, codes and defaults of the block-diagonal matrix multiplier.
// ----------------------------------------------------------------------------
package bdmm_pkg;

  localparam int DEF_MAX_OUT    = 8;
  localparam int DEF_MAX_IN     = 8;
  localparam int DEF_MAX_BLOCKS = 256;
  localparam int DEF_MAX_YCOLS  = 256;

  localparam int VAL_W   = 32;
  localparam int ACC_W   = 64;
  localparam int ROW_W   = 11;
  localparam int COL_W   = 8;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_OUT   = 2'd0,
    REG_COLS_IN    = 2'd1,
    REG_NUM_BLOCKS = 2'd2,
    REG_Y_COLS     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                    operation;
    logic [2:0]              entry_row;
    logic [2:0]              entry_col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } out_item_t;

  // control that travels with one multiply-accumulate step
  typedef struct packed {
    logic valid;
    logic live;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT,
    ST_EMIT_LOAD
  } state_t;

endpackage

// File: design/block_diagonal_matrix_multiply.sv
// ----------------------------------------------------------------------------
// block_diagonal_matrix_multiply
// Product of (I kron X) with a column-major stream of Y, one shared
// multiply-accumulate unit stepping over the output rows of each element.
// ----------------------------------------------------------------------------
//   channel  | handshake                 | payload
//   feed     | feed_valid / feed_ready   | feed   (operation, entry, value)
//   result   | result_valid/result_ready | result (row, col, value, last)
//   cfg      | cfg_we                    | cfg_index, cfg_data
//
// A load item is written to the X store as it is taken, if in range. A Y
// element issues one MAC step per output row, then waits in DRAIN until
// the MAC pipeline has written its last accumulator. The element that
// closes a segment then reads out rows_out results via EMIT and EMIT_LOAD;
// the last one waits in the output register while the next item is taken.
// After reset all MAX_OUT * MAX_IN X store entries are swept to zero, with
// feed_ready low. A stalled result holds the sequencer before its next row.
module block_diagonal_matrix_multiply #(
  parameter int MAX_OUT    = bdmm_pkg::DEF_MAX_OUT,
  parameter int MAX_IN     = bdmm_pkg::DEF_MAX_IN,
  parameter int MAX_BLOCKS = bdmm_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_YCOLS  = bdmm_pkg::DEF_MAX_YCOLS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               feed_valid,
  output logic                               feed_ready,
  input  bdmm_pkg::in_item_t                 feed,
  output logic                               result_valid,
  input  logic                               result_ready,
  output bdmm_pkg::out_item_t                result,
  input  logic                               cfg_we,
  input  logic [bdmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdmm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int XDEPTH = MAX_OUT * MAX_IN;
  localparam int XA_W   = (XDEPTH > 1) ? $clog2(XDEPTH) : 1;
  localparam int H_W    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int RO_W   = $clog2(MAX_OUT + 1);
  localparam int CI_W   = $clog2(MAX_IN + 1);
  localparam int SEG_W  = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int NB_W   = $clog2(MAX_BLOCKS + 1);
  localparam int BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int YC_W   = $clog2(MAX_YCOLS + 1);
  localparam int YCOL_W = (MAX_YCOLS > 1) ? $clog2(MAX_YCOLS) : 1;

  bdmm_pkg::state_t state, state_next;

  // raw register bits, clamped copies below
  logic [3:0] rows_out_raw;
  logic [3:0] cols_in_raw;
  logic [8:0] num_blocks_raw;
  logic [8:0] y_cols_raw;

  logic [RO_W-1:0] ro_eff;
  logic [CI_W-1:0] ci_eff;
  logic [NB_W-1:0] nb_eff;
  logic [YC_W-1:0] yc_eff;

  logic [H_W-1:0]              h;
  logic [SEG_W-1:0]            seg_pos;
  logic [BLK_W-1:0]            block_pos;
  logic [YCOL_W-1:0]           col_pos;
  logic [bdmm_pkg::ROW_W-1:0]  row_base;
  logic [XA_W-1:0]             clr_addr;
  logic [MAX_OUT-1:0]          acc_live;
  logic                        acc_live_rd;
  logic signed [bdmm_pkg::VAL_W-1:0] y_val;

  logic                        iss_valid;
  logic [H_W-1:0]              iss_h;
  bdmm_pkg::mac_ctl_t          mac_ctl;

  logic                        x_we;
  logic [XA_W-1:0]             x_waddr;
  logic [bdmm_pkg::VAL_W-1:0]  x_wdata;
  logic [XA_W-1:0]             x_raddr;
  logic [bdmm_pkg::VAL_W-1:0]  x_rdata;
  logic [bdmm_pkg::ACC_W-1:0]  acc_rdata;

  logic                        mac_wr_valid;
  logic [H_W-1:0]              mac_wr_addr;
  logic signed [bdmm_pkg::ACC_W-1:0] mac_wr_data;

  logic cfg_hit, restart, issue, h_inc, h_clr, seg_inc, pos_adv, emit_load;
  logic h_last, seg_last, block_last, col_last, clr_last, load_ok;
  logic [XA_W-1:0] load_addr;

  // clamp: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    logic [31:0] t_ro, t_ci, t_nb, t_yc;
    t_ro = 32'(rows_out_raw);
    t_ci = 32'(cols_in_raw);
    t_nb = 32'(num_blocks_raw);
    t_yc = 32'(y_cols_raw);
    if (t_ro == 32'd0) t_ro = 32'd1; else if (t_ro > 32'(MAX_OUT)) t_ro = 32'(MAX_OUT);
    if (t_ci == 32'd0) t_ci = 32'd1; else if (t_ci > 32'(MAX_IN)) t_ci = 32'(MAX_IN);
    if (t_nb == 32'd0) t_nb = 32'd1;
    else if (t_nb > 32'(MAX_BLOCKS)) t_nb = 32'(MAX_BLOCKS);
    if (t_yc == 32'd0) t_yc = 32'd1;
    else if (t_yc > 32'(MAX_YCOLS)) t_yc = 32'(MAX_YCOLS);
    ro_eff = RO_W'(t_ro);
    ci_eff = CI_W'(t_ci);
    nb_eff = NB_W'(t_nb);
    yc_eff = YC_W'(t_yc);
  end

  assign h_last     = (32'(h) + 32'd1) >= 32'(ro_eff);
  assign seg_last   = (32'(seg_pos) + 32'd1) >= 32'(ci_eff);
  assign block_last = (32'(block_pos) + 32'd1) >= 32'(nb_eff);
  assign col_last   = (32'(col_pos) + 32'd1) >= 32'(yc_eff);
  assign clr_last   = 32'(clr_addr) == 32'(XDEPTH - 1);
  assign load_ok    = (32'(feed.entry_row) < 32'(MAX_OUT)) &&
                      (32'(feed.entry_col) < 32'(MAX_IN));
  assign load_addr  = XA_W'(32'(feed.entry_row) * 32'(MAX_IN) + 32'(feed.entry_col));
  assign x_raddr    = XA_W'(32'(h) * 32'(MAX_IN) + 32'(seg_pos));

  always_comb begin
    case (bdmm_pkg::reg_idx_t'(cfg_index))
      bdmm_pkg::REG_ROWS_OUT,
      bdmm_pkg::REG_COLS_IN,
      bdmm_pkg::REG_NUM_BLOCKS,
      bdmm_pkg::REG_Y_COLS:    cfg_hit = cfg_we;
      default:                 cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdmm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    feed_ready = 1'b0;
    x_we       = 1'b0;
    x_waddr    = load_addr;
    x_wdata    = feed.value;
    restart    = cfg_hit;
    issue      = 1'b0;
    h_inc      = 1'b0;
    h_clr      = 1'b0;
    seg_inc    = 1'b0;
    pos_adv    = 1'b0;
    emit_load  = 1'b0;
    case (state)
      bdmm_pkg::ST_CLEAR: begin
        x_we    = 1'b1;
        x_waddr = clr_addr;
        x_wdata = '0;
        if (clr_last) state_next = bdmm_pkg::ST_IDLE;
      end
      bdmm_pkg::ST_IDLE: begin
        feed_ready = 1'b1;
        if (feed_valid) begin
          if (feed.operation == bdmm_pkg::OP_LOAD) begin
            x_we    = load_ok;
            restart = 1'b1;
          end else begin
            h_clr      = 1'b1;
            state_next = bdmm_pkg::ST_MAC;
          end
        end
      end
      bdmm_pkg::ST_MAC: begin
        issue = 1'b1;
        if (h_last) begin
          h_clr      = 1'b1;
          state_next = bdmm_pkg::ST_DRAIN;
        end else begin
          h_inc = 1'b1;
        end
      end
      bdmm_pkg::ST_DRAIN: begin
        // wait for the last accumulator write before reading any back
        if (!iss_valid && !mac_wr_valid) begin
          if (seg_last) begin
            state_next = bdmm_pkg::ST_EMIT;
          end else begin
            seg_inc    = 1'b1;
            state_next = bdmm_pkg::ST_IDLE;
          end
        end
      end
      bdmm_pkg::ST_EMIT: begin
        if (!result_valid || result_ready) state_next = bdmm_pkg::ST_EMIT_LOAD;
      end
      bdmm_pkg::ST_EMIT_LOAD: begin
        emit_load = 1'b1;
        if (h_last) begin
          pos_adv    = 1'b1;
          h_clr      = 1'b1;
          state_next = bdmm_pkg::ST_IDLE;
        end else begin
          h_inc      = 1'b1;
          state_next = bdmm_pkg::ST_EMIT;
        end
      end
      default: state_next = bdmm_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_out_raw   <= 4'd1;
      cols_in_raw    <= 4'd1;
      num_blocks_raw <= 9'd1;
      y_cols_raw     <= 9'd1;
      h              <= '0;
      seg_pos        <= '0;
      block_pos      <= '0;
      col_pos        <= '0;
      row_base       <= '0;
      clr_addr       <= '0;
      acc_live       <= '0;
      iss_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (bdmm_pkg::reg_idx_t'(cfg_index))
          bdmm_pkg::REG_ROWS_OUT:   rows_out_raw   <= cfg_data[3:0];
          bdmm_pkg::REG_COLS_IN:    cols_in_raw    <= cfg_data[3:0];
          bdmm_pkg::REG_NUM_BLOCKS: num_blocks_raw <= cfg_data;
          bdmm_pkg::REG_Y_COLS:     y_cols_raw     <= cfg_data;
          default: ;
        endcase
      end
      if (state == bdmm_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      iss_valid <= issue;
      if (h_clr) begin
        h <= '0;
      end else if (h_inc) begin
        h <= h + 1'b1;
      end
      if (restart || pos_adv) begin
        acc_live <= '0;
      end else if (mac_wr_valid) begin
        acc_live[mac_wr_addr] <= 1'b1;
      end
      if (restart) begin
        seg_pos   <= '0;
        block_pos <= '0;
        col_pos   <= '0;
        row_base  <= '0;
      end else if (seg_inc) begin
        seg_pos <= seg_pos + 1'b1;
      end else if (pos_adv) begin
        seg_pos <= '0;
        if (block_last) begin
          block_pos <= '0;
          row_base  <= '0;
          col_pos   <= col_last ? '0 : col_pos + 1'b1;
        end else begin
          block_pos <= block_pos + 1'b1;
          row_base  <= row_base + bdmm_pkg::ROW_W'(ro_eff);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_h       <= h;
    acc_live_rd <= acc_live[h];
    if (feed_valid && feed_ready) y_val <= feed.value;
  end

  assign mac_ctl.valid = iss_valid;
  assign mac_ctl.live  = acc_live_rd;

  bdmm_ram #(
    .WIDTH (bdmm_pkg::VAL_W),
    .DEPTH (XDEPTH)
  ) u_xram (
    .clk   (clk),
    .we    (x_we),
    .waddr (x_waddr),
    .wdata (x_wdata),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  bdmm_ram #(
    .WIDTH (bdmm_pkg::ACC_W),
    .DEPTH (MAX_OUT)
  ) u_acc_ram (
    .clk   (clk),
    .we    (mac_wr_valid),
    .waddr (mac_wr_addr),
    .wdata (mac_wr_data),
    .raddr (h),
    .rdata (acc_rdata)
  );

  bdmm_mac #(
    .ADDR_W (H_W)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .addr     (iss_h),
    .x        (x_rdata),
    .y        (y_val),
    .acc_in   (acc_rdata),
    .wr_valid (mac_wr_valid),
    .wr_addr  (mac_wr_addr),
    .wr_data  (mac_wr_data)
  );

  bdmm_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (emit_load),
    .row          (row_base + bdmm_pkg::ROW_W'(h)),
    .col          (bdmm_pkg::COL_W'(col_pos)),
    .acc          (acc_rdata),
    .live         (acc_live_rd),
    .last         (h_last),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// File: design/bdmm_ram.sv
// ----------------------------------------------------------------------------
// bdmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/bdmm_mac.sv
// ----------------------------------------------------------------------------
// bdmm_mac
// Shared multiply-accumulate unit: registered 32x32 product, then a
// saturating 64-bit add into the accumulator value read from the store.
// ----------------------------------------------------------------------------
module bdmm_mac #(
  parameter int ADDR_W = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bdmm_pkg::mac_ctl_t                 ctl,
  input  logic [ADDR_W-1:0]                  addr,
  input  logic signed [bdmm_pkg::VAL_W-1:0]  x,
  input  logic signed [bdmm_pkg::VAL_W-1:0]  y,
  input  logic signed [bdmm_pkg::ACC_W-1:0]  acc_in,
  output logic                               wr_valid,
  output logic [ADDR_W-1:0]                  wr_addr,
  output logic signed [bdmm_pkg::ACC_W-1:0]  wr_data
);

  logic signed [bdmm_pkg::ACC_W-1:0] prod;
  logic signed [bdmm_pkg::ACC_W-1:0] acc;
  logic                              valid;
  logic [bdmm_pkg::ACC_W:0]          sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= x * y;
    // an accumulator not written since the last clear reads as zero
    acc     <= ctl.live ? acc_in : '0;
    wr_addr <= addr;
  end

  always_comb begin
    sum = {acc[bdmm_pkg::ACC_W-1], acc} + {prod[bdmm_pkg::ACC_W-1], prod};
    if (sum[bdmm_pkg::ACC_W] != sum[bdmm_pkg::ACC_W-1]) begin
      // clamp on overflow, direction from the true sign
      wr_data = sum[bdmm_pkg::ACC_W] ? {1'b1, {(bdmm_pkg::ACC_W-1){1'b0}}}
                                     : {1'b0, {(bdmm_pkg::ACC_W-1){1'b1}}};
    end else begin
      wr_data = sum[bdmm_pkg::ACC_W-1:0];
    end
  end

  assign wr_valid = valid;

endmodule

// File: design/bdmm_out.sv
// ----------------------------------------------------------------------------
// bdmm_out
// Result register: scales an accumulator to Q16.16 with saturation and
// holds the item until the consumer takes it.
// ----------------------------------------------------------------------------
module bdmm_out (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic [bdmm_pkg::ROW_W-1:0]           row,
  input  logic [bdmm_pkg::COL_W-1:0]           col,
  input  logic signed [bdmm_pkg::ACC_W-1:0]    acc,
  input  logic                                 live,
  input  logic                                 last,
  input  logic                                 result_ready,
  output logic                                 result_valid,
  output bdmm_pkg::out_item_t                  result
);

  logic signed [bdmm_pkg::ACC_W-1:0] a;
  logic signed [bdmm_pkg::VAL_W-1:0] q;

  always_comb begin
    a = live ? acc : '0;
    // in range when bits 63..47 all match the sign
    if (!a[63] && (|a[62:47])) begin
      q = {1'b0, {(bdmm_pkg::VAL_W-1){1'b1}}};
    end else if (a[63] && !(&a[62:47])) begin
      q = {1'b1, {(bdmm_pkg::VAL_W-1){1'b0}}};
    end else begin
      q = a[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_row   <= row;
      result.out_col   <= col;
      result.out_value <= q;
      result.last      <= last;
    end
  end

endmodule

// File: design/bdmm_checker.sv
// ----------------------------------------------------------------------------
// bdmm_checker
// Port-level checks of the block-diagonal matrix multiplier.
// ----------------------------------------------------------------------------
module bdmm_checker (
  input logic                clk,
  input logic                rst,
  input logic                feed_valid,
  input logic                feed_ready,
  input bdmm_pkg::in_item_t  feed,
  input logic                result_valid,
  input logic                result_ready,
  input bdmm_pkg::out_item_t result
);

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // a Y element occupies the shared unit
  a_busy: assert property (@(posedge clk) disable iff (rst)
    feed_valid && feed_ready && (feed.operation == bdmm_pkg::OP_DATA) |=> !feed_ready)
    else $error("ready while a Y element is in work");

  // a load finishes in its own cycle
  a_load: assert property (@(posedge clk) disable iff (rst)
    feed_valid && feed_ready && (feed.operation == bdmm_pkg::OP_LOAD) |=> feed_ready)
    else $error("load item stalled the feed");

  // results are only produced by the sequencer, never while it waits for items
  a_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!feed_ready))
    else $error("result appeared from idle");

endmodule

bind block_diagonal_matrix_multiply bdmm_checker u_bdmm_checker (.*);
